FILE: rtl/core/cags_pkg.sv
// Shared types, codes and field widths of the cellular automaton generation step unit.
`default_nettype none
package cags_pkg;

  localparam int STATE_BITS_DEF = 4;
  localparam int CODE_W         = 4;
  localparam int INDEX_W        = 12;
  localparam int VERDICT_W      = 3;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 8;

  localparam logic [1:0] SEEN_FULL = 2'd2;
  localparam logic [1:0] SEEN_MAX  = 2'd3;

  typedef enum logic {
    MODE_RULE = 1'b0,
    MODE_CELL = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_FIRING_CODE    = 1'b0,
    CFG_UNDEFINED_CODE = 1'b1
  } cfg_idx_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_SUCCESS   = 3'd0,
    VERDICT_ALL_FIRED = 3'd1,
    VERDICT_PARTLY    = 3'd2,
    VERDICT_UNDEFINED = 3'd3,
    VERDICT_TOO_SMALL = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [CODE_W-1:0] firing;
    logic [CODE_W-1:0] undefined;
  } codes_t;

  typedef struct packed {
    logic advance;
    logic cell_valid;
    logic last;
  } stage_t;

endpackage
`default_nettype wire

FILE: rtl/core/cags_row_stats.sv
// Per-row firing and undefined-rule flags, and the verdict for the word that ends a row.
`default_nettype none
module cags_row_stats #(
  parameter int STATE_BITS = cags_pkg::STATE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cags_pkg::codes_t                  codes,
  input  wire cags_pkg::stage_t                  stage,
  input  wire logic [STATE_BITS-1:0]             next_cell,
  output logic [cags_pkg::VERDICT_W-1:0]         verdict
);
  import cags_pkg::*;

  logic              any_fired_r, any_fired_nxt;
  logic              all_fired_r, all_fired_nxt;
  logic              any_undef_r, any_undef_nxt;
  logic [CODE_W-1:0] next_code;
  logic              fired_now;
  logic              undef_now;
  verdict_t          verdict_sel;

  assign next_code = CODE_W'(next_cell);
  assign fired_now = stage.cell_valid && (next_code == codes.firing);
  assign undef_now = stage.cell_valid && !fired_now && (next_code == codes.undefined);

  always_comb begin
    any_fired_nxt = any_fired_r | fired_now;
    all_fired_nxt = all_fired_r & (!stage.cell_valid | fired_now);
    any_undef_nxt = any_undef_r | undef_now;
  end

  always_comb begin
    if (!stage.last) begin
      verdict_sel = VERDICT_SUCCESS;
    end else if (!stage.cell_valid) begin
      verdict_sel = VERDICT_TOO_SMALL;
    end else if (any_undef_nxt) begin
      verdict_sel = VERDICT_UNDEFINED;
    end else if (any_fired_nxt) begin
      verdict_sel = all_fired_nxt ? VERDICT_ALL_FIRED : VERDICT_PARTLY;
    end else begin
      verdict_sel = VERDICT_SUCCESS;
    end
  end

  assign verdict = verdict_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_fired_r <= 1'b0;
      all_fired_r <= 1'b1;
      any_undef_r <= 1'b0;
    end else if (stage.advance) begin
      if (stage.last) begin
        any_fired_r <= 1'b0;
        all_fired_r <= 1'b1;
        any_undef_r <= 1'b0;
      end else begin
        any_fired_r <= any_fired_nxt;
        all_fired_r <= all_fired_nxt;
        any_undef_r <= any_undef_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cellular_automaton_generation_step_unit.sv
// Top level of the cellular automaton generation step unit: rule memory, cell window and result register.
`default_nettype none
// The unit accepts one word per clock cycle while the output is not stalled, and delivers each
// result through the lookup stage and the output register; that rate is set by the single-port
// rule memory, which takes one rule write or one lookup with a registered read for every word.
// Rule words (in_tuser low) write one entry of the table; cell words (in_tuser high) stream a
// row from the left boundary cell to the right boundary cell marked by in_tlast. Each cell from
// the third on yields the next state of the inner cell before it, and the word ending the row
// carries the verdict with out_tlast high. Table entries hold no defined value until written,
// so no clearing pass runs after reset. Configuration may be written only while the unit is idle.
module cellular_automaton_generation_step_unit #(
  parameter int STATE_BITS = cags_pkg::STATE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [cags_pkg::CODE_W-1:0]     cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // in_tdata fields from bit 0: rule_index[11:0], rule_value[15:12], cell_state[19:16], zero pad.
  input  wire logic [cags_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser fields from bit 0: mode.
  input  wire logic                            in_tuser,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata fields from bit 0: next_state[3:0], verdict[6:4], zero pad.
  output logic [cags_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser fields from bit 0: cell_valid.
  output logic                                 out_tuser,
  output logic                                 out_tlast
);
  import cags_pkg::*;

  localparam int ADDR_W      = 3 * STATE_BITS;
  localparam int TABLE_DEPTH = 1 << ADDR_W;

  codes_t                  codes_r;
  logic [STATE_BITS-1:0]   rule_mem_r [TABLE_DEPTH];
  logic [STATE_BITS-1:0]   rd_data_r;
  logic [STATE_BITS-1:0]   older_r;
  logic [STATE_BITS-1:0]   middle_r;
  logic [1:0]              seen_r;
  logic                    s1_valid_r;
  logic                    s1_cell_valid_r;
  logic                    s1_last_r;
  logic                    out_valid_r;
  logic                    out_cell_valid_r;
  logic                    out_last_r;
  logic [CODE_W-1:0]       out_next_r;
  logic [VERDICT_W-1:0]    out_verdict_r;

  logic [INDEX_W-1:0]      rule_index;
  logic [CODE_W-1:0]       rule_value;
  logic [CODE_W-1:0]       cell_state;
  logic [STATE_BITS-1:0]   cur_cell;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    in_acc;
  logic                    is_cell;
  logic                    window_full;
  logic                    has_result;
  logic                    do_read;
  logic                    do_write;
  logic                    out_free;
  logic                    s1_adv;
  stage_t                  stage;
  logic [VERDICT_W-1:0]    verdict;

  assign rule_index  = in_tdata[11:0];
  assign rule_value  = in_tdata[15:12];
  assign cell_state  = in_tdata[19:16];
  assign cur_cell    = STATE_BITS'(cell_state);
  assign wr_addr     = ADDR_W'(rule_index);
  assign rd_addr     = {older_r, middle_r, cur_cell};

  assign in_acc      = in_tvalid && in_tready;
  assign is_cell     = (mode_t'(in_tuser) == MODE_CELL);
  assign window_full = (seen_r >= SEEN_FULL);
  assign has_result  = is_cell && (window_full || in_tlast);
  assign do_read     = in_acc && is_cell && window_full;
  assign do_write    = in_acc && !is_cell;

  assign out_free    = !out_valid_r || out_tready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_tready   = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.firing    <= 4'd15;
      codes_r.undefined <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRING_CODE:    codes_r.firing    <= cfg_wdata;
        CFG_UNDEFINED_CODE: codes_r.undefined <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      rule_mem_r[wr_addr] <= STATE_BITS'(rule_value);
    end
    if (do_read) begin
      rd_data_r <= rule_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r  <= '0;
      middle_r <= '0;
      seen_r   <= '0;
    end else if (in_acc && is_cell) begin
      if (in_tlast) begin
        older_r  <= '0;
        middle_r <= '0;
        seen_r   <= '0;
      end else begin
        older_r  <= middle_r;
        middle_r <= cur_cell;
        if (seen_r != SEEN_MAX) begin
          seen_r <= seen_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc && has_result) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_result) begin
      s1_cell_valid_r <= window_full;
      s1_last_r       <= in_tlast;
    end
  end

  assign stage.advance    = s1_adv;
  assign stage.cell_valid = s1_cell_valid_r;
  assign stage.last       = s1_last_r;

  cags_row_stats #(
    .STATE_BITS(STATE_BITS)
  ) u_row_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .codes     (codes_r),
    .stage     (stage),
    .next_cell (rd_data_r),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cell_valid_r <= s1_cell_valid_r;
      out_last_r       <= s1_last_r;
      out_next_r       <= s1_cell_valid_r ? CODE_W'(rd_data_r) : '0;
      out_verdict_r    <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_verdict_r, out_next_r};
  assign out_tuser  = out_cell_valid_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("Pending lookup lost while the output was stalled.");

  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_cell && in_tlast |=> seen_r == 2'd0)
    else $error("Cell window not cleared after the end of a row.");

  a_mid_row_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser && out_tdata[6:4] == VERDICT_SUCCESS)
    else $error("Mid-row result without an updated cell or with a verdict.");

  a_short_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[3:0] == 4'd0 && out_tdata[6:4] == VERDICT_TOO_SMALL)
    else $error("Result without an updated cell is not a short-row verdict.");

  a_no_read_on_rule: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_read && do_write))
    else $error("Rule memory written and read for the same word.");
`endif

endmodule
`default_nettype wire
